// File: hw/rtl/aat_pkg.sv
// aat_pkg: shared types and codes for the alias/address table.
// No dependencies.
`default_nettype none
package aat_pkg;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_LOC    = 3'd4,
    REQ_LIST   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ALIAS_EXISTS = 3'd1,
    ST_ADDR_EXISTS  = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_FULL         = 3'd4,
    ST_UNCHANGED    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_EMIT,
    S_WAIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load;       // capture request
    logic       clr_idx;    // index to zero
    logic       inc_idx;    // index + 1
    logic       mem_rd;     // read entry at index (shift reads index + 1)
    logic       rd_next;    // read at index + 1
    logic       wr_new;     // write request entry at count
    logic       wr_addr;    // write new address at index
    logic       wr_shift;   // write read entry to index
    logic       cnt_inc;
    logic       cnt_dec;
    logic       note_hit;   // record match of scan
    logic       out_load;   // fill output register
    logic [2:0] out_sel;    // 0 echo request, 1 scanned entry, 2 empty not found
    logic [2:0] out_status;
    logic       out_last;
    logic       out_set_last;  // mark the held search item as final
    logic       out_zero_addr;
    logic       out_use_req_addr;
    logic       out_use_found;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       idx_end;     // index >= count
    logic       next_end;    // index + 1 >= count
    logic       alias_eq;
    logic       addr_eq;
    logic       loc_eq;
    logic       any_alias;
    logic       any_addr;
    logic       full;
    logic       found_eq_addr; // found entry's address equals request address
    logic       emitted;       // a search result was sent
    logic [2:0] req;
  } sts_t;

  localparam logic [2:0] SEL_ECHO  = 3'd0;
  localparam logic [2:0] SEL_ENTRY = 3'd1;
  localparam logic [2:0] SEL_NONE  = 3'd2;

endpackage
`default_nettype wire

// File: hw/rtl/aat_ram.sv
// aat_ram: generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module aat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/aat_ctrl.sv
// aat_ctrl: request sequencer of the alias/address table.
// Depends on aat_pkg.
`default_nettype none
module aat_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire aat_pkg::sts_t  sts_i,
  output aat_pkg::cmd_t       cmd_o
);
  aat_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic pend_q, pend_d;     // search item loaded but not yet posted
  logic fire_out;

  assign fire_out    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == aat_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aat_pkg::S_IDLE: begin
        if (in_valid_i && (sts_i.req inside {[aat_pkg::REQ_ADD:aat_pkg::REQ_LIST]}))
          state_d = aat_pkg::S_SCAN_RD;
      end
      aat_pkg::S_SCAN_RD: begin
        state_d = sts_i.idx_end ? aat_pkg::S_EMIT : aat_pkg::S_SCAN_CHK;
      end
      aat_pkg::S_SCAN_CHK: begin
        if ((sts_i.req == aat_pkg::REQ_LOC && sts_i.loc_eq) || sts_i.req == aat_pkg::REQ_LIST)
          state_d = aat_pkg::S_WAIT;
        else if (sts_i.alias_eq && (sts_i.req inside
                 {aat_pkg::REQ_LOOKUP, aat_pkg::REQ_UPDATE, aat_pkg::REQ_DELETE}))
          state_d = (sts_i.req == aat_pkg::REQ_DELETE) ? aat_pkg::S_SHIFT_RD
                                                       : aat_pkg::S_EMIT;
        else state_d = aat_pkg::S_SCAN_RD;
      end
      aat_pkg::S_WAIT: begin
        if (!pend_q && (!out_valid_q || fire_out)) state_d = aat_pkg::S_SCAN_RD;
      end
      aat_pkg::S_SHIFT_RD: begin
        state_d = sts_i.next_end ? aat_pkg::S_EMIT : aat_pkg::S_SHIFT_WR;
      end
      aat_pkg::S_SHIFT_WR: state_d = aat_pkg::S_SHIFT_RD;
      aat_pkg::S_EMIT: begin
        if (!out_valid_q || fire_out) state_d = aat_pkg::S_IDLE;
      end
      default: state_d = aat_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    logic is_srch;
    logic space;
    is_srch = (sts_i.req == aat_pkg::REQ_LOC) || (sts_i.req == aat_pkg::REQ_LIST);
    space   = !out_valid_q || fire_out;
    cmd_o = '0;
    out_valid_d = out_valid_q && !fire_out;
    pend_d = pend_q;
    case (state_q)
      aat_pkg::S_IDLE: begin
        cmd_o.load = in_valid_i;
        cmd_o.clr_idx = 1'b1;
      end
      aat_pkg::S_SCAN_RD: cmd_o.mem_rd = !sts_i.idx_end;
      aat_pkg::S_SCAN_CHK: begin
        cmd_o.note_hit = 1'b1;
        if (!(((sts_i.alias_eq && sts_i.req != aat_pkg::REQ_ADD)) && !is_srch))
          cmd_o.inc_idx = !is_srch ||
                          !((sts_i.req == aat_pkg::REQ_LOC && sts_i.loc_eq) ||
                            sts_i.req == aat_pkg::REQ_LIST);
      end
      aat_pkg::S_WAIT: begin
        if (pend_q) begin
          // a further match shows the held item is not the final one
          out_valid_d = 1'b1;
          pend_d = 1'b0;
        end else if (space) begin
          // hold the scanned entry until the scan shows whether it ends the run
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel = aat_pkg::SEL_ENTRY;
          cmd_o.out_status = aat_pkg::ST_OK;
          cmd_o.inc_idx = 1'b1;
          pend_d = 1'b1;
        end
      end
      aat_pkg::S_SHIFT_RD: cmd_o.rd_next = !sts_i.next_end;
      aat_pkg::S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.inc_idx = 1'b1;
      end
      aat_pkg::S_EMIT: begin
        if (space) begin
          out_valid_d = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_sel = aat_pkg::SEL_ECHO;
          cmd_o.out_zero_addr = 1'b1;
          case (sts_i.req)
            aat_pkg::REQ_ADD: begin
              if (sts_i.any_alias) cmd_o.out_status = aat_pkg::ST_ALIAS_EXISTS;
              else if (sts_i.any_addr) cmd_o.out_status = aat_pkg::ST_ADDR_EXISTS;
              else if (sts_i.full) cmd_o.out_status = aat_pkg::ST_FULL;
              else begin
                cmd_o.out_status = aat_pkg::ST_OK;
                cmd_o.out_zero_addr = 1'b0;
                cmd_o.out_use_req_addr = 1'b1;
                cmd_o.wr_new = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            aat_pkg::REQ_LOOKUP, aat_pkg::REQ_DELETE: begin
              if (!sts_i.any_alias) cmd_o.out_status = aat_pkg::ST_NOT_FOUND;
              else begin
                cmd_o.out_status = aat_pkg::ST_OK;
                cmd_o.out_zero_addr = 1'b0;
                cmd_o.out_use_found = 1'b1;
                cmd_o.cnt_dec = (sts_i.req == aat_pkg::REQ_DELETE);
              end
            end
            aat_pkg::REQ_UPDATE: begin
              if (!sts_i.any_alias) cmd_o.out_status = aat_pkg::ST_NOT_FOUND;
              else if (sts_i.found_eq_addr) cmd_o.out_status = aat_pkg::ST_UNCHANGED;
              else begin
                cmd_o.out_status = aat_pkg::ST_OK;
                cmd_o.out_zero_addr = 1'b0;
                cmd_o.out_use_req_addr = 1'b1;
                cmd_o.wr_addr = 1'b1;
              end
            end
            default: begin
              // search end: post the held item as final, or report nothing found
              if (sts_i.emitted) begin
                cmd_o.out_load = 1'b0;
                cmd_o.out_set_last = 1'b1;
                pend_d = 1'b0;
              end else begin
                cmd_o.out_sel = aat_pkg::SEL_NONE;
                cmd_o.out_status = aat_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aat_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      pend_q <= pend_d;
    end
  end

  // a final result loaded at the end of a request is posted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aat_pkg::S_EMIT && cmd_o.out_load) |=> out_valid_q)
    else $error("result not posted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_new |-> !sts_i.full))
    else $error("append into full table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("held item overlaps a posted one");
endmodule
`default_nettype wire

// File: hw/rtl/aat_dp.sv
// aat_dp: entry storage, scan index, compares and output register.
// Depends on aat_pkg and aat_ram.
`default_nettype none
module aat_dp #(
  parameter int Capacity = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     req_type_i,
  input  wire logic [15:0]    alias_head_i,
  input  wire logic [63:0]    alias_tail_i,
  input  wire logic [31:0]    address_i,
  input  wire logic [15:0]    location_i,
  input  wire aat_pkg::cmd_t  cmd_i,
  output aat_pkg::sts_t       sts_o,
  output logic [2:0]          status_o,
  output logic [15:0]         out_alias_head_o,
  output logic [63:0]         out_alias_tail_o,
  output logic [31:0]         out_address_o,
  output logic                last_o
);
  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);
  localparam int EW = 112;

  logic [2:0]  req_q;
  logic [15:0] ah_q, loc_q;
  logic [63:0] at_q;
  logic [31:0] addr_q, found_addr_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic hit_alias_q, hit_addr_q, emitted_q;
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;
  logic we;
  logic [CW:0] idx_p1;

  assign idx_p1 = {1'b0, idx_q} + 1'b1;

  // storage: one word of alias head, tail and address
  always_comb begin
    raddr = cmd_i.rd_next ? idx_p1[AW-1:0] : idx_q[AW-1:0];
    we = cmd_i.wr_new || cmd_i.wr_addr || cmd_i.wr_shift;
    waddr = cmd_i.wr_new ? cnt_q[AW-1:0] : idx_q[AW-1:0];
    if (cmd_i.wr_shift) wdata = rdata;
    else wdata = {ah_q, at_q, addr_q};
  end

  aat_ram #(.Width(EW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      emitted_q <= 1'b0;
      hit_alias_q <= 1'b0;
      hit_addr_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.cnt_dec) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_p1[CW-1:0];
      if (cmd_i.load) begin
        emitted_q <= 1'b0;
        hit_alias_q <= 1'b0;
        hit_addr_q <= 1'b0;
      end
      if (cmd_i.out_load && cmd_i.out_sel == aat_pkg::SEL_ENTRY) emitted_q <= 1'b1;
      if (cmd_i.note_hit) begin
        if (sts_o.alias_eq) hit_alias_q <= 1'b1;
        if (sts_o.addr_eq) hit_addr_q <= 1'b1;
      end
    end
  end

  // request and found address capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      ah_q <= alias_head_i;
      at_q <= alias_tail_i;
      addr_q <= address_i;
      loc_q <= location_i;
    end
    if (cmd_i.note_hit && sts_o.alias_eq) found_addr_q <= rdata[31:0];
  end

  // status toward the controller
  always_comb begin
    sts_o.idx_end  = (idx_q >= cnt_q);
    sts_o.next_end = (idx_p1 >= {1'b0, cnt_q});
    sts_o.alias_eq = (rdata[EW-1:32] == {ah_q, at_q});
    sts_o.addr_eq  = (rdata[31:0] == addr_q);
    sts_o.loc_eq   = (rdata[31:16] == loc_q);
    sts_o.any_alias = hit_alias_q;
    sts_o.any_addr = hit_addr_q;
    sts_o.full = (cnt_q >= CW'(Capacity));
    sts_o.found_eq_addr = (found_addr_q == addr_q);
    sts_o.emitted = emitted_q;
    sts_o.req = cmd_i.load ? req_type_i : req_q;
  end

  // output register; a held search item only gets its last flag set
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= cmd_i.out_status;
      last_o <= cmd_i.out_last;
      case (cmd_i.out_sel)
        aat_pkg::SEL_ENTRY: begin
          out_alias_head_o <= rdata[EW-1:96];
          out_alias_tail_o <= rdata[95:32];
          out_address_o <= rdata[31:0];
        end
        aat_pkg::SEL_NONE: begin
          out_alias_head_o <= '0;
          out_alias_tail_o <= '0;
          out_address_o <= '0;
        end
        default: begin
          out_alias_head_o <= ah_q;
          out_alias_tail_o <= at_q;
          if (cmd_i.out_zero_addr) out_address_o <= '0;
          else if (cmd_i.out_use_found) out_address_o <= found_addr_q;
          else out_address_o <= addr_q;
        end
      endcase
    end else if (cmd_i.out_set_last) begin
      last_o <= 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Capacity)) else $error("count over capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> cnt_q != '0) else $error("count underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_shift |-> idx_p1 < {1'b0, cnt_q}) else $error("shift past end");
endmodule
`default_nettype wire

// File: hw/rtl/alias_address_table.sv
// alias_address_table: top level, joins controller and datapath.
// Depends on aat_pkg, aat_ctrl, aat_dp, aat_ram.
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  s_axis  | in  | alias_head, alias_tail, address, location         | req_type
//  m_axis  | out | out_alias_head, out_alias_tail, out_address       | status, tlast=last
//
// A request scans the entries (scan read, scan check) and ends in the emit
// state; delete first shifts each later entry down (shift read, shift write).
// The scan uses the single registered read port of the entry RAM. Search holds
// each matching item in the output register until the next match or the end
// of the scan settles its last flag, and pauses while the register is full.
// Reset clears the entry count but not the RAM; no clearing pass is needed.
`default_nettype none
module alias_address_table #(
  parameter int Capacity = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // alias_head, alias_tail, address, location
  input  wire logic [2:0]   s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,  // out_alias_head, out_alias_tail, out_address
  output logic [2:0]        m_axis_tuser,  // status
  output logic              m_axis_tlast
);
  aat_pkg::cmd_t cmd;
  aat_pkg::sts_t sts;
  logic [15:0] oah;
  logic [63:0] oat;
  logic [31:0] oad;

  aat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  aat_dp #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni,
    .req_type_i(s_axis_tuser),
    .alias_head_i(s_axis_tdata[15:0]),
    .alias_tail_i(s_axis_tdata[79:16]),
    .address_i(s_axis_tdata[111:80]),
    .location_i(s_axis_tdata[127:112]),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(m_axis_tuser),
    .out_alias_head_o(oah), .out_alias_tail_o(oat), .out_address_o(oad),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {oad, oat, oah};
endmodule
`default_nettype wire
